// ----- rtl/hist2d_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hist2d_pkg
// Shared constants, codes and transaction types of the 2-D histogram core.
// ----------------------------------------------------------------------------
package hist2d_pkg;

   localparam int MAX_BINS_X   = 64;
   localparam int MAX_BINS_Y   = 64;
   localparam int COUNT_WIDTH  = 32;
   localparam int STORE_DEPTH  = MAX_BINS_X * MAX_BINS_Y;

   localparam int COORD_WIDTH  = 32;
   localparam int WIDE_WIDTH   = COORD_WIDTH + 2;
   localparam int BINS_WIDTH   = 7;
   localparam int INDEX_WIDTH  = 12;
   localparam int RESULT_WIDTH = 32;
   localparam int BIN_X_WIDTH  = $clog2(MAX_BINS_X);
   localparam int BIN_Y_WIDTH  = $clog2(MAX_BINS_Y);
   localparam int QUO_WIDTH    = BINS_WIDTH;
   localparam int STEP_WIDTH   = $clog2(QUO_WIDTH);
   localparam int NUM_WIDTH    = COORD_WIDTH + BINS_WIDTH;
   localparam int ONE_Q16      = 65536;

   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_X_LOW  = 3'd0,
      CSR_X_HIGH = 3'd1,
      CSR_Y_LOW  = 3'd2,
      CSR_Y_HIGH = 3'd3,
      CSR_BINS_X = 3'd4,
      CSR_BINS_Y = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x_low;
      logic signed [COORD_WIDTH-1:0] x_high;
      logic signed [COORD_WIDTH-1:0] y_low;
      logic signed [COORD_WIDTH-1:0] y_high;
      logic [BINS_WIDTH-1:0]         bins_x;
      logic [BINS_WIDTH-1:0]         bins_y;
   } cfg_type;

   typedef struct packed {
      op_type                        operation;
      logic signed [COORD_WIDTH-1:0] x_value;
      logic signed [COORD_WIDTH-1:0] y_value;
      logic [INDEX_WIDTH-1:0]        read_index;
   } req_type;

   typedef struct packed {
      logic                    accepted;
      logic [INDEX_WIDTH-1:0]  bin_index;
      logic [RESULT_WIDTH-1:0] bin_count;
      logic [RESULT_WIDTH-1:0] total_count;
   } rsp_type;

   typedef struct packed {
      op_type                 op;
      logic                   hit;
      logic [INDEX_WIDTH-1:0] index;
   } cmd_type;

endpackage
`default_nettype wire

// ----- rtl/hist2d_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hist2d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hist2d_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/hist2d_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hist2d_front
// Takes request transactions, checks range and finds the bin with a shared
// restoring divider (one quotient bit per cycle), then queues a command.
// ----------------------------------------------------------------------------
module hist2d_front (
   input  logic                clock,
   input  logic                reset,
   input  hist2d_pkg::cfg_type cfg,
   input  logic                sweeping,
   input  logic                req_valid,
   output logic                req_stall,
   input  hist2d_pkg::req_type req_data,
   output logic                push,
   output hist2d_pkg::cmd_type push_cmd,
   input  logic                full
);
   import hist2d_pkg::*;

   typedef enum logic [4:0] {
      F_IDLE  = 5'b00001,
      F_SETUP = 5'b00010,
      F_MUL   = 5'b00100,
      F_DIV   = 5'b01000,
      F_PUSH  = 5'b10000
   } front_state_type;

   typedef struct packed {
      logic                   in_range;
      logic [COORD_WIDTH-1:0] off;
      logic [COORD_WIDTH-1:0] span;
   } axis_type;

   function automatic axis_type axis_setup(input logic signed [COORD_WIDTH-1:0] v,
                                           input logic signed [COORD_WIDTH-1:0] lo,
                                           input logic signed [COORD_WIDTH-1:0] hi);
      logic signed [WIDE_WIDTH-1:0] v_w;
      logic signed [WIDE_WIDTH-1:0] lo_w;
      logic signed [WIDE_WIDTH-1:0] hi_w;
      logic signed [WIDE_WIDTH-1:0] top;
      logic signed [WIDE_WIDTH-1:0] diff;
      logic signed [WIDE_WIDTH-1:0] width;
      axis_type                     a;
      v_w   = WIDE_WIDTH'(v);
      lo_w  = WIDE_WIDTH'(lo);
      hi_w  = WIDE_WIDTH'(hi);
      // empty range is taken as width 1.0
      top   = (hi_w <= lo_w) ? lo_w + WIDE_WIDTH'(ONE_Q16) : hi_w;
      diff  = v_w - lo_w;
      width = top - lo_w;
      a.in_range = (v_w >= lo_w) && (v_w <= top);
      a.off      = diff[COORD_WIDTH-1:0];
      a.span     = width[COORD_WIDTH-1:0];
      return a;
   endfunction

   function automatic logic [BINS_WIDTH-1:0] eff_bins(input logic [BINS_WIDTH-1:0] b,
                                                      input logic [BINS_WIDTH-1:0] maxb);
      if (b == '0) begin
         return BINS_WIDTH'(1);
      end
      if (b > maxb) begin
         return maxb;
      end
      return b;
   endfunction

   front_state_type        state_ff, state_in;
   req_type                item_ff, item_in;
   logic                   axis_ff, axis_in;
   logic                   hit_ff, hit_in;
   logic [COORD_WIDTH-1:0] off_x_ff, off_x_in, off_y_ff, off_y_in;
   logic [COORD_WIDTH-1:0] span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic [BINS_WIDTH-1:0]  nb_x_ff, nb_x_in, nb_y_ff, nb_y_in;
   logic [NUM_WIDTH-1:0]   rem_ff, rem_in, dvs_ff, dvs_in;
   logic [QUO_WIDTH-1:0]   quo_ff, quo_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic [BIN_X_WIDTH-1:0] bin_x_ff, bin_x_in;
   logic [BIN_Y_WIDTH-1:0] bin_y_ff, bin_y_in;

   axis_type               ax_x, ax_y;
   logic [COORD_WIDTH-1:0] off_cur, span_cur;
   logic [BINS_WIDTH-1:0]  nb_cur, bin_cur;
   logic                   ge;
   logic [QUO_WIDTH-1:0]   quo_next;
   logic [INDEX_WIDTH-1:0] flat;

   assign ax_x     = axis_setup(item_ff.x_value, cfg.x_low, cfg.x_high);
   assign ax_y     = axis_setup(item_ff.y_value, cfg.y_low, cfg.y_high);
   assign off_cur  = axis_ff ? off_y_ff : off_x_ff;
   assign span_cur = axis_ff ? span_y_ff : span_x_ff;
   assign nb_cur   = axis_ff ? nb_y_ff : nb_x_ff;
   assign ge       = rem_ff >= dvs_ff;
   assign quo_next = {quo_ff[QUO_WIDTH-2:0], ge};
   assign bin_cur  = (quo_next >= nb_cur) ? nb_cur - BINS_WIDTH'(1) : quo_next;
   assign flat     = INDEX_WIDTH'(INDEX_WIDTH'(bin_y_ff) * INDEX_WIDTH'(nb_x_ff)
                                  + INDEX_WIDTH'(bin_x_ff));

   assign req_stall = (state_ff != F_IDLE) || sweeping;
   assign push      = (state_ff == F_PUSH) && !full;

   always_comb begin
      push_cmd.op    = item_ff.operation;
      push_cmd.hit   = hit_ff;
      push_cmd.index = '0;
      if (item_ff.operation == OP_READ) begin
         push_cmd.index = item_ff.read_index;
      end else if (item_ff.operation == OP_ADD && hit_ff) begin
         push_cmd.index = flat;
      end
   end

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      axis_in   = axis_ff;
      hit_in    = hit_ff;
      off_x_in  = off_x_ff;
      off_y_in  = off_y_ff;
      span_x_in = span_x_ff;
      span_y_in = span_y_ff;
      nb_x_in   = nb_x_ff;
      nb_y_in   = nb_y_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      bin_x_in  = bin_x_ff;
      bin_y_in  = bin_y_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid && !req_stall) begin
               item_in = req_data;
               hit_in  = 1'b0;
               state_in = (req_data.operation == OP_ADD) ? F_SETUP : F_PUSH;
            end
         end
         F_SETUP: begin
            off_x_in  = ax_x.off;
            off_y_in  = ax_y.off;
            span_x_in = ax_x.span;
            span_y_in = ax_y.span;
            nb_x_in   = eff_bins(cfg.bins_x, BINS_WIDTH'(MAX_BINS_X));
            nb_y_in   = eff_bins(cfg.bins_y, BINS_WIDTH'(MAX_BINS_Y));
            hit_in    = ax_x.in_range && ax_y.in_range;
            axis_in   = 1'b0;
            state_in  = (ax_x.in_range && ax_y.in_range) ? F_MUL : F_PUSH;
         end
         F_MUL: begin
            rem_in   = NUM_WIDTH'(off_cur) * NUM_WIDTH'(nb_cur);
            dvs_in   = NUM_WIDTH'(span_cur) << (QUO_WIDTH - 1);
            quo_in   = '0;
            step_in  = STEP_WIDTH'(QUO_WIDTH - 1);
            state_in = F_DIV;
         end
         F_DIV: begin
            if (ge) begin
               rem_in = rem_ff - dvs_ff;
            end
            dvs_in  = dvs_ff >> 1;
            quo_in  = quo_next;
            step_in = step_ff - STEP_WIDTH'(1);
            if (step_ff == '0) begin
               if (!axis_ff) begin
                  bin_x_in = BIN_X_WIDTH'(bin_cur);
                  axis_in  = 1'b1;
                  state_in = F_MUL;
               end else begin
                  bin_y_in = BIN_Y_WIDTH'(bin_cur);
                  state_in = F_PUSH;
               end
            end
         end
         F_PUSH: begin
            if (!full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff   <= item_in;
      axis_ff   <= axis_in;
      hit_ff    <= hit_in;
      off_x_ff  <= off_x_in;
      off_y_ff  <= off_y_in;
      span_x_ff <= span_x_in;
      span_y_ff <= span_y_in;
      nb_x_ff   <= nb_x_in;
      nb_y_ff   <= nb_y_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      bin_x_ff  <= bin_x_in;
      bin_y_ff  <= bin_y_in;
   end

endmodule
`default_nettype wire

// ----- rtl/hist2d_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hist2d_queue
// Short command FIFO between the classifying front and the store back end.
// ----------------------------------------------------------------------------
module hist2d_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hist2d_pkg::cmd_type push_cmd,
   output logic                full,
   input  logic                pop,
   output hist2d_pkg::cmd_type head_cmd,
   output logic                empty
);
   import hist2d_pkg::*;

   cmd_type                 entry_ff [QUEUE_DEPTH];
   cmd_type                 entry_in;
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_WIDTH-1:0] count_ff, count_in;

   function automatic logic [QPTR_WIDTH-1:0] next_ptr(input logic [QPTR_WIDTH-1:0] p);
      return (p == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_WIDTH'(1);
   endfunction

   assign entry_in = push_cmd;
   assign full     = count_ff == QCOUNT_WIDTH'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + QCOUNT_WIDTH'(1);
         2'b01:   count_in = count_ff - QCOUNT_WIDTH'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/hist2d_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hist2d_back
// Executes queued commands on the bin store: read-modify-write for counted
// samples, bin reads, and a clearing sweep after reset and on clear.
// ----------------------------------------------------------------------------
module hist2d_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   output logic                pop,
   input  hist2d_pkg::cmd_type head_cmd,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hist2d_pkg::rsp_type rsp_data,
   output logic                sweeping
);
   import hist2d_pkg::*;

   typedef enum logic [2:0] {
      B_IDLE  = 3'b001,
      B_DATA  = 3'b010,
      B_CLEAR = 3'b100
   } back_state_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      return (&c) ? c : c + COUNT_WIDTH'(1);
   endfunction

   back_state_type         state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [INDEX_WIDTH-1:0] addr_ff, addr_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   out_free;
   logic                   ram_wr_en, ram_rd_en;
   logic [INDEX_WIDTH-1:0] ram_wr_addr, ram_rd_addr;
   logic [COUNT_WIDTH-1:0] ram_wr_data, ram_rd_data, bumped;

   hist2d_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign bumped    = sat_inc(ram_rd_data);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign sweeping  = state_ff == B_CLEAR;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = head_cmd.index;
      case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               if ((head_cmd.op == OP_ADD && head_cmd.hit) || head_cmd.op == OP_READ) begin
                  pop       = 1'b1;
                  ram_rd_en = 1'b1;
                  cmd_in    = head_cmd;
                  state_in  = B_DATA;
               end else if (out_free) begin
                  pop                  = 1'b1;
                  rsp_valid_in         = 1'b1;
                  rsp_in.accepted      = 1'b0;
                  rsp_in.bin_index     = '0;
                  rsp_in.bin_count     = '0;
                  rsp_in.total_count   = RESULT_WIDTH'(total_ff);
                  if (head_cmd.op == OP_CLEAR) begin
                     total_in           = '0;
                     rsp_in.total_count = '0;
                     addr_in            = '0;
                     state_in           = B_CLEAR;
                  end
               end
            end
         end
         B_DATA: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.bin_index = cmd_ff.index;
               if (cmd_ff.op == OP_ADD) begin
                  ram_wr_en          = 1'b1;
                  ram_wr_addr        = cmd_ff.index;
                  ram_wr_data        = bumped;
                  total_in           = sat_inc(total_ff);
                  rsp_in.accepted    = 1'b1;
                  rsp_in.bin_count   = RESULT_WIDTH'(bumped);
                  rsp_in.total_count = RESULT_WIDTH'(sat_inc(total_ff));
               end else begin
                  rsp_in.accepted    = 1'b0;
                  rsp_in.bin_count   = RESULT_WIDTH'(ram_rd_data);
                  rsp_in.total_count = RESULT_WIDTH'(total_ff);
               end
               state_in = B_IDLE;
            end
         end
         B_CLEAR: begin
            ram_wr_en = 1'b1;
            addr_in   = addr_ff + INDEX_WIDTH'(1);
            if (addr_ff == INDEX_WIDTH'(STORE_DEPTH - 1)) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         addr_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

endmodule
`default_nettype wire

// ----- rtl/histogram_2d_binning_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_2d_binning_core
// Two-dimensional histogram over a configured Q16.16 rectangle with a
// 64 x 64 bin store, bin reads and clear.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   hist2d_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall   hist2d_pkg::rsp_type
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// A sample inside the range holds the front through accept, setup, one
// divider pass per axis (product, then a quotient bit per cycle) and the
// push; a dropped sample skips the divider, and read, clear and no-op go
// from accept straight to the push. Reset and every clear start a sweep
// of all 4096 store entries during which req_stall is high. A stalled
// rsp lets up to two queued transactions build up behind it.
// ----------------------------------------------------------------------------
module histogram_2d_binning_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  hist2d_pkg::req_type                    req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output hist2d_pkg::rsp_type                    rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [hist2d_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [hist2d_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import hist2d_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    q_push, q_full, q_pop, q_empty, sweeping;
   cmd_type q_push_cmd, q_head_cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_X_LOW:  cfg_in.x_low  = csr_data[COORD_WIDTH-1:0];
            CSR_X_HIGH: cfg_in.x_high = csr_data[COORD_WIDTH-1:0];
            CSR_Y_LOW:  cfg_in.y_low  = csr_data[COORD_WIDTH-1:0];
            CSR_Y_HIGH: cfg_in.y_high = csr_data[COORD_WIDTH-1:0];
            CSR_BINS_X: cfg_in.bins_x = csr_data[BINS_WIDTH-1:0];
            CSR_BINS_Y: cfg_in.bins_y = csr_data[BINS_WIDTH-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_low  <= '0;
         cfg_ff.x_high <= COORD_WIDTH'(ONE_Q16);
         cfg_ff.y_low  <= '0;
         cfg_ff.y_high <= COORD_WIDTH'(ONE_Q16);
         cfg_ff.bins_x <= BINS_WIDTH'(16);
         cfg_ff.bins_y <= BINS_WIDTH'(16);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hist2d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .sweeping  (sweeping),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full)
   );

   hist2d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head_cmd (q_head_cmd),
      .empty    (q_empty)
   );

   hist2d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (q_empty),
      .pop       (q_pop),
      .head_cmd  (q_head_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .sweeping  (sweeping)
   );

`ifndef SYNTH
   a_count_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.bin_count <= rsp_data.total_count)
      else $error("bin count above running total");

   a_counted_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |-> rsp_data.bin_count != '0)
      else $error("counted sample left an empty bin");

   a_no_take_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweeping |-> !(req_valid && !req_stall))
      else $error("transaction taken during store sweep");
`endif

endmodule
`default_nettype wire
